// File: rtl/core/ultrasonic_ranger_median_unit_macros.svh
// assertion macros used by the ranger top level
`ifndef ULTRASONIC_RANGER_MEDIAN_UNIT_MACROS_SVH
`define ULTRASONIC_RANGER_MEDIAN_UNIT_MACROS_SVH

// same-cycle implication, held off during reset
`define URSM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define URSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ursm_pkg.sv
// types and constants for the ultrasonic ranger with median filter
package ursm_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int DIST_W     = 16;
  localparam int TIMER_W    = 20;
  localparam int TRIES_W    = 4;
  localparam int USED_W     = 4;
  localparam int ELAPSED_W  = DIST_W + 1;
  localparam int SCALE_W    = 9;
  localparam int PROD_W     = ELAPSED_W + SCALE_W;
  localparam int DIST_SHIFT = 8;
  localparam int SDIST_W    = PROD_W - DIST_SHIFT;

  localparam logic [SCALE_W-1:0] DIST_SCALE     = 9'd439;
  localparam logic [TIMER_W-1:0] TRIG_LOW_TICKS = 20'd2;
  localparam logic [TRIES_W-1:0] TRIES_MAX      = 4'd15;

  localparam logic [15:0] TIMEOUT_RST   = 16'd30000;
  localparam logic [15:0] MIN_DIST_RST  = 16'd200;
  localparam logic [15:0] MAX_DIST_RST  = 16'd40000;
  localparam logic [19:0] GAP_RST       = 20'd60000;
  localparam logic [3:0]  SAMPLES_RST   = 4'd5;
  localparam logic [3:0]  TRIES_RST     = 4'd10;
  localparam logic [7:0]  TRIG_W_RST    = 8'd20;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TRIG_LOW,
    PH_TRIG_HIGH,
    PH_WAIT_RISE,
    PH_TIME_HIGH,
    PH_GAP
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT,
    CFG_MIN_DIST,
    CFG_MAX_DIST,
    CFG_GAP,
    CFG_SAMPLES,
    CFG_TRIES,
    CFG_TRIG_WIDTH
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] timeout_us;
    logic [15:0] min_distance;
    logic [15:0] max_distance;
    logic [19:0] gap_ticks;
    logic [3:0]  samples_wanted;
    logic [3:0]  tries_allowed;
    logic [7:0]  trigger_width;
  } cfg_t;

  typedef struct packed {
    logic              clear;
    logic              insert;
    logic [DIST_W-1:0] value;
  } sort_ctl_t;

  typedef struct packed {
    logic              trig;
    logic              busy;
    logic              done;
    logic              found;
    logic [DIST_W-1:0] distance;
    logic [USED_W-1:0] samples_used;
  } res_t;

endpackage

// File: rtl/core/ursm_cfg.sv
// configuration register file
module ursm_cfg import ursm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TIMEOUT:    cfg_d.timeout_us     = cfg_data_i[15:0];
        CFG_MIN_DIST:   cfg_d.min_distance   = cfg_data_i[15:0];
        CFG_MAX_DIST:   cfg_d.max_distance   = cfg_data_i[15:0];
        CFG_GAP:        cfg_d.gap_ticks      = cfg_data_i[19:0];
        CFG_SAMPLES:    cfg_d.samples_wanted = cfg_data_i[3:0];
        CFG_TRIES:      cfg_d.tries_allowed  = cfg_data_i[3:0];
        CFG_TRIG_WIDTH: cfg_d.trigger_width  = cfg_data_i[7:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_us     <= TIMEOUT_RST;
      cfg_q.min_distance   <= MIN_DIST_RST;
      cfg_q.max_distance   <= MAX_DIST_RST;
      cfg_q.gap_ticks      <= GAP_RST;
      cfg_q.samples_wanted <= SAMPLES_RST;
      cfg_q.tries_allowed  <= TRIES_RST;
      cfg_q.trigger_width  <= TRIG_W_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/ursm_sorter.sv
// insertion-sorted sample cells with median select
module ursm_sorter import ursm_pkg::*; #(
  parameter int SAMPLE_SLOTS = 8,
  localparam int CNT_W = $clog2(SAMPLE_SLOTS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sort_ctl_t         ctl_i,
  output logic [CNT_W-1:0]  count_o,
  output logic [DIST_W-1:0] median_o
);

  logic [DIST_W-1:0]     slot_q [SAMPLE_SLOTS];
  logic [CNT_W-1:0]      count_q, count_d;
  logic [SAMPLE_SLOTS-1:0] gt;
  logic [SAMPLE_SLOTS-1:0] gt_ext;
  logic                  ins_ok;
  logic [CNT_W-1:0]      half;
  logic [DIST_W-1:0]     lo, hi;
  logic [DIST_W:0]       pair_sum;

  assign ins_ok = ctl_i.insert && !ctl_i.clear && (count_q < CNT_W'(SAMPLE_SLOTS));

  always_comb begin
    gt_ext[0] = 1'b0;
    for (int k = 0; k < SAMPLE_SLOTS; k++) begin
      gt[k] = (CNT_W'(k) < count_q) && (slot_q[k] > ctl_i.value);
    end
    for (int k = 1; k < SAMPLE_SLOTS; k++) begin
      gt_ext[k] = gt[k-1];
    end
  end

  for (genvar k = 0; k < SAMPLE_SLOTS; k++) begin : g_cell
    localparam logic [CNT_W-1:0] Idx = CNT_W'(k);
    logic [DIST_W-1:0] left;
    logic [DIST_W-1:0] slot_d;
    logic              take;

    if (k == 0) begin : g_first
      assign left = ctl_i.value;
    end else begin : g_rest
      assign left = slot_q[k-1];
    end

    // a cell loads when the new value lands here or everything above it moves up
    assign take   = ins_ok && ((Idx == count_q) || gt[k]);
    assign slot_d = gt_ext[k] ? left : ctl_i.value;

    always_ff @(posedge clk_i) begin
      if (take) begin
        slot_q[k] <= slot_d;
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctl_i.clear) begin
      count_d = '0;
    end else if (ins_ok) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_comb begin
    half = count_q >> 1;
    lo   = '0;
    hi   = '0;
    for (int k = 0; k < SAMPLE_SLOTS; k++) begin
      if (CNT_W'(k) == half) begin
        hi = slot_q[k];
      end
      if (CNT_W'(k + 1) == half) begin
        lo = slot_q[k];
      end
    end
    pair_sum = {1'b0, lo} + {1'b0, hi};
    if (count_q == '0) begin
      median_o = '0;
    end else if (count_q[0]) begin
      median_o = hi;
    end else begin
      median_o = pair_sum[DIST_W:1];
    end
  end

  assign count_o = count_q;

endmodule

// File: rtl/core/ursm_seq.sv
// measurement sequencer: trigger, echo timing, tries and gaps
module ursm_seq import ursm_pkg::*; #(
  parameter int SAMPLE_SLOTS = 8,
  localparam int CNT_W = $clog2(SAMPLE_SLOTS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              cmd_i,
  input  logic              echo_i,
  input  cfg_t              cfg_i,
  input  logic [CNT_W-1:0]  count_i,
  input  logic [DIST_W-1:0] median_i,
  output sort_ctl_t         sort_o,
  output res_t              res_o
);

  phase_e               phase_q, phase_d;
  logic [TIMER_W-1:0]   timer_q, timer_d;
  logic [DIST_W-1:0]    pulse_q, pulse_d;
  logic [TRIES_W-1:0]   tries_q, tries_d;

  logic                 decide;
  logic                 fresh;
  logic                 end_try;
  logic [TRIES_W-1:0]   tries_eff;
  logic [CNT_W-1:0]     cnt_eff;
  logic [TIMER_W-1:0]   timer_inc;
  logic [ELAPSED_W-1:0] elapsed;
  logic [PROD_W-1:0]    prod;
  logic [SDIST_W-1:0]   dist_raw;
  logic                 in_range;

  assign timer_inc = timer_q + TIMER_W'(1);
  assign elapsed   = {1'b0, pulse_q} + ELAPSED_W'(1);
  assign prod      = PROD_W'(elapsed) * PROD_W'(DIST_SCALE);
  assign dist_raw  = prod[PROD_W-1:DIST_SHIFT];
  assign in_range  = (dist_raw >= SDIST_W'(cfg_i.min_distance))
                  && (dist_raw <= SDIST_W'(cfg_i.max_distance));

  always_comb begin
    phase_d   = phase_q;
    timer_d   = timer_q;
    pulse_d   = pulse_q;
    tries_d   = tries_q;
    sort_o    = '0;
    res_o     = '0;
    decide    = 1'b0;
    fresh     = 1'b0;
    end_try   = 1'b0;
    tries_eff = tries_q;
    cnt_eff   = count_i;

    if (accept_i) begin
      case (phase_q)
        PH_IDLE: begin
          if (cmd_i) begin
            sort_o.clear = 1'b1;
            tries_d      = '0;
            pulse_d      = '0;
            tries_eff    = '0;
            cnt_eff      = '0;
            fresh        = 1'b1;
            decide       = 1'b1;
          end
        end
        PH_GAP: begin
          if (timer_q < cfg_i.gap_ticks) begin
            timer_d    = timer_inc;
            res_o.busy = 1'b1;
          end else begin
            decide = 1'b1;
          end
        end
        PH_TRIG_LOW: begin
          res_o.busy = 1'b1;
          if (timer_inc >= TRIG_LOW_TICKS) begin
            phase_d = PH_TRIG_HIGH;
            timer_d = '0;
          end else begin
            timer_d = timer_inc;
          end
        end
        PH_TRIG_HIGH: begin
          res_o.busy = 1'b1;
          res_o.trig = 1'b1;
          if (timer_inc >= TIMER_W'(cfg_i.trigger_width)) begin
            phase_d = PH_WAIT_RISE;
            timer_d = '0;
          end else begin
            timer_d = timer_inc;
          end
        end
        PH_WAIT_RISE: begin
          res_o.busy = 1'b1;
          if (echo_i) begin
            phase_d = PH_TIME_HIGH;
            pulse_d = '0;
          end else begin
            timer_d = timer_inc;
            end_try = timer_inc > TIMER_W'(cfg_i.timeout_us);
          end
        end
        PH_TIME_HIGH: begin
          res_o.busy = 1'b1;
          if (!echo_i) begin
            pulse_d       = elapsed[DIST_W-1:0];
            sort_o.insert = in_range;
            sort_o.value  = dist_raw[DIST_W-1:0];
            end_try       = 1'b1;
          end else if (elapsed > ELAPSED_W'(cfg_i.timeout_us)) begin
            end_try = 1'b1;
          end else begin
            pulse_d = elapsed[DIST_W-1:0];
          end
        end
        default: begin
          phase_d = PH_IDLE;
          timer_d = '0;
        end
      endcase

      if (end_try) begin
        if (tries_q < TRIES_MAX) begin
          tries_d = tries_q + TRIES_W'(1);
        end
        phase_d = PH_GAP;
        timer_d = '0;
      end

      if (decide) begin
        if ((32'(cnt_eff) < 32'(cfg_i.samples_wanted)) && (32'(cnt_eff) < SAMPLE_SLOTS)
            && (tries_eff < cfg_i.tries_allowed)) begin
          // first trigger-low tick of the next try
          phase_d    = PH_TRIG_LOW;
          timer_d    = TIMER_W'(1);
          res_o.busy = 1'b1;
        end else begin
          phase_d            = PH_IDLE;
          timer_d            = '0;
          res_o.done         = 1'b1;
          res_o.found        = (cnt_eff != '0);
          res_o.distance     = fresh ? '0 : median_i;
          res_o.samples_used = USED_W'(cnt_eff);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      timer_q <= '0;
      pulse_q <= '0;
      tries_q <= '0;
    end else begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      pulse_q <= pulse_d;
      tries_q <= tries_d;
    end
  end

endmodule

// File: rtl/core/ultrasonic_ranger_median_unit.sv
// top level of the ultrasonic ranger with median filter
// latency: a beat's result is shown in the cycle after it is accepted
// throughput: one input beat per cycle while the input is not stalled, set by the single output register
// a stalled result holds the output register and stalls the input side only
// reset clears phase, timers, tries, sample count and registers to defaults
// the sample cells are not reset and are read only after being written
`include "ultrasonic_ranger_median_unit_macros.svh"

module ultrasonic_ranger_median_unit import ursm_pkg::*; #(
  parameter int SAMPLE_SLOTS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  cmd_i,
  input  logic                  echo_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  trig_o,
  output logic                  busy_res_o,
  output logic                  done_res_o,
  output logic                  found_o,
  output logic [DIST_W-1:0]     distance_o,
  output logic [USED_W-1:0]     samples_used_o
);

  localparam int CNT_W = $clog2(SAMPLE_SLOTS + 1);

  cfg_t              cfg;
  sort_ctl_t         sort_ctl;
  res_t              res;
  res_t              res_q;
  logic              out_valid_q, out_valid_d;
  logic              accept;
  logic [CNT_W-1:0]  count;
  logic [DIST_W-1:0] median;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  ursm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ursm_seq #(
    .SAMPLE_SLOTS (SAMPLE_SLOTS)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .cmd_i    (cmd_i),
    .echo_i   (echo_i),
    .cfg_i    (cfg),
    .count_i  (count),
    .median_i (median),
    .sort_o   (sort_ctl),
    .res_o    (res)
  );

  ursm_sorter #(
    .SAMPLE_SLOTS (SAMPLE_SLOTS)
  ) u_sorter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (sort_ctl),
    .count_o  (count),
    .median_o (median)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign trig_o         = res_q.trig;
  assign busy_res_o     = res_q.busy;
  assign done_res_o     = res_q.done;
  assign found_o        = res_q.found;
  assign distance_o     = res_q.distance;
  assign samples_used_o = res_q.samples_used;

  `URSM_ASSERT_IMPL(a_no_stall_when_empty, !out_valid_o, !in_stall_o,
                    "input stalled with empty output register")
  `URSM_ASSERT_NEXT(a_beat_reaches_output, in_valid_i && !in_stall_o, out_valid_o,
                    "accepted beat did not reach the output register")
  `URSM_ASSERT_IMPL(a_trig_only_busy, out_valid_o && trig_o, busy_res_o && !done_res_o,
                    "trigger driven outside a running measurement")
  `URSM_ASSERT_IMPL(a_no_distance_unfound, out_valid_o && !found_o, distance_o == '0,
                    "distance reported without a valid reading")

endmodule

// File: tb/sv/ursm_checker.sv
// checker for the ultrasonic ranger: mirrors every accepted input beat and compares each result beat
`timescale 1ns / 1ps

module ursm_checker import ursm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic                  cmd_i,
  input  logic                  echo_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic                  trig_i,
  input  logic                  busy_res_i,
  input  logic                  done_res_i,
  input  logic                  found_i,
  input  logic [DIST_W-1:0]     distance_i,
  input  logic [USED_W-1:0]     samples_used_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    done_count_o,
  output int                    found_count_o
);

  localparam int unsigned SLOTS = 8;

  cfg_t               regs;
  phase_e             ph;
  logic [TIMER_W-1:0] timer;
  logic [DIST_W-1:0]  pulse_len;
  logic [TRIES_W-1:0] tries;
  logic [USED_W-1:0]  held;
  logic [DIST_W-1:0]  ranked [SLOTS];
  res_t               awaited [$];

  function automatic void keep_reading(int unsigned v);
    int unsigned i;
    if (held >= SLOTS) return;
    i = held;
    while (i > 0 && ranked[i-1] > v) begin
      ranked[i] = ranked[i-1];
      i--;
    end
    ranked[i] = v[DIST_W-1:0];
    held++;
  endfunction

  function automatic void close_try();
    if (tries < TRIES_MAX) tries++;
    ph = PH_GAP;
    timer = '0;
  endfunction

  function automatic res_t ranger_tick(logic c, logic e);
    res_t        r;
    int unsigned want, n, d, elapsed, dist_raw;
    logic        decide;
    r = '0;
    r.busy = 1'b1;
    decide = 1'b0;
    if (ph == PH_IDLE) begin
      if (!c) begin
        r.busy = 1'b0;
        return r;
      end
      tries = '0;
      held = '0;
      pulse_len = '0;
      decide = 1'b1;
    end else if (ph == PH_GAP) begin
      if (timer < regs.gap_ticks) begin
        timer++;
        return r;
      end
      decide = 1'b1;
    end
    if (decide) begin
      want = (regs.samples_wanted > SLOTS) ? SLOTS : regs.samples_wanted;
      if (held < want && tries < regs.tries_allowed) begin
        ph = PH_TRIG_LOW;
        timer = '0;
      end else begin
        n = held;
        d = 0;
        if (n != 0) begin
          if (n[0]) d = ranked[n/2];
          else d = (32'(ranked[n/2-1]) + 32'(ranked[n/2])) >> 1;
        end
        r.busy = 1'b0;
        r.done = 1'b1;
        r.found = (n != 0);
        r.distance = d[DIST_W-1:0];
        r.samples_used = n[USED_W-1:0];
        ph = PH_IDLE;
        timer = '0;
        return r;
      end
    end
    case (ph)
      PH_TRIG_LOW: begin
        timer++;
        if (timer >= TRIG_LOW_TICKS) begin
          ph = PH_TRIG_HIGH;
          timer = '0;
        end
      end
      PH_TRIG_HIGH: begin
        r.trig = 1'b1;
        timer++;
        if (timer >= regs.trigger_width) begin
          ph = PH_WAIT_RISE;
          timer = '0;
        end
      end
      PH_WAIT_RISE: begin
        if (e) begin
          ph = PH_TIME_HIGH;
          pulse_len = '0;
        end else begin
          timer++;
          if (timer > regs.timeout_us) close_try();
        end
      end
      PH_TIME_HIGH: begin
        elapsed = 32'(pulse_len) + 1;
        if (!e) begin
          dist_raw = (elapsed * DIST_SCALE) >> DIST_SHIFT;
          pulse_len = elapsed[DIST_W-1:0];
          if (dist_raw >= regs.min_distance && dist_raw <= regs.max_distance)
            keep_reading(dist_raw);
          close_try();
        end else if (elapsed > regs.timeout_us) begin
          close_try();
        end else begin
          pulse_len = elapsed[DIST_W-1:0];
        end
      end
      default: begin
        ph = PH_IDLE;
        timer = '0;
        r.busy = 1'b0;
      end
    endcase
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t head;
    if (!rst_ni) begin
      regs.timeout_us     = TIMEOUT_RST;
      regs.min_distance   = MIN_DIST_RST;
      regs.max_distance   = MAX_DIST_RST;
      regs.gap_ticks      = GAP_RST;
      regs.samples_wanted = SAMPLES_RST;
      regs.tries_allowed  = TRIES_RST;
      regs.trigger_width  = TRIG_W_RST;
      ph = PH_IDLE;
      timer = '0;
      pulse_len = '0;
      tries = '0;
      held = '0;
      awaited.delete();
      fail_count_o = 0;
      pending_o = 0;
      done_count_o = 0;
      found_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (awaited.size() == 0) begin
          $error("result beat with no prediction waiting");
          fail_count_o++;
        end else begin
          head = awaited.pop_front();
          check_field("trig", head.trig, trig_i);
          check_field("busy_res", head.busy, busy_res_i);
          check_field("done_res", head.done, done_res_i);
          check_field("found", head.found, found_i);
          check_field("distance", head.distance, distance_i);
          check_field("samples_used", head.samples_used, samples_used_i);
          if (head.done) done_count_o++;
          if (head.found) found_count_o++;
        end
      end
      if (in_valid_i && !in_stall_i) awaited.push_back(ranger_tick(cmd_i, echo_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TIMEOUT:    regs.timeout_us     = cfg_data_i[15:0];
          CFG_MIN_DIST:   regs.min_distance   = cfg_data_i[15:0];
          CFG_MAX_DIST:   regs.max_distance   = cfg_data_i[15:0];
          CFG_GAP:        regs.gap_ticks      = cfg_data_i[19:0];
          CFG_SAMPLES:    regs.samples_wanted = cfg_data_i[3:0];
          CFG_TRIES:      regs.tries_allowed  = cfg_data_i[3:0];
          CFG_TRIG_WIDTH: regs.trigger_width  = cfg_data_i[7:0];
          default: ;
        endcase
      end
      pending_o = awaited.size();
    end
  end

endmodule

// File: tb/sv/tb_ultrasonic_ranger_median_unit.sv
// testbench top for the ultrasonic ranger: stimulus, stall patterns and verdict
`timescale 1ns / 1ps

module tb_ultrasonic_ranger_median_unit;
  import ursm_pkg::*;

  localparam int unsigned RANDOM_BEATS = 700;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned LONG_HOLD    = 300;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  cmd_i;
  logic                  echo_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  trig_o;
  logic                  busy_res_o;
  logic                  done_res_o;
  logic                  found_o;
  logic [DIST_W-1:0]     distance_o;
  logic [USED_W-1:0]     samples_used_o;

  int          fails, pending, done_cnt, found_cnt;
  int          idle_pct, stall_pct, hold_reqs;
  int unsigned beats, settings, cycles;
  cfg_t        cur;

  ultrasonic_ranger_median_unit u_dut (.*);

  ursm_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .cmd_i          (cmd_i),
    .echo_i         (echo_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .trig_i         (trig_o),
    .busy_res_i     (busy_res_o),
    .done_res_i     (done_res_o),
    .found_i        (found_o),
    .distance_i     (distance_o),
    .samples_used_i (samples_used_o),
    .fail_count_o   (fails),
    .pending_o      (pending),
    .done_count_o   (done_cnt),
    .found_count_o  (found_cnt)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("run stopped at the cycle limit with %0d results outstanding", pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin : receiver
    int hold_left;
    int served;
    hold_left = 0;
    served = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (served != hold_reqs) begin
        served = hold_reqs;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99, 0) < stall_pct);
      end
    end
  end

  function automatic logic rand_bit();
    return 1'($urandom_range(1, 0));
  endfunction

  // cmd during busy phases: mostly low, sometimes a start that must be ignored
  function automatic logic stray_cmd();
    return ($urandom_range(3, 0) == 0);
  endfunction

  task automatic send_beat(input logic c, input logic e);
    while ($urandom_range(99, 0) < idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    cmd_i <= c;
    echo_i <= e;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats++;
  endtask

  task automatic noise_ticks(input int unsigned n);
    repeat (n) send_beat(stray_cmd(), rand_bit());
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic put_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
  endtask

  task automatic set_cfg(input int unsigned to, mn, mx, gap, sw, ta, tw);
    drain();
    put_reg(CFG_TIMEOUT, CFG_DATA_W'(to));
    put_reg(CFG_MIN_DIST, CFG_DATA_W'(mn));
    put_reg(CFG_MAX_DIST, CFG_DATA_W'(mx));
    put_reg(CFG_GAP, CFG_DATA_W'(gap));
    put_reg(CFG_SAMPLES, CFG_DATA_W'(sw));
    put_reg(CFG_TRIES, CFG_DATA_W'(ta));
    put_reg(CFG_TRIG_WIDTH, CFG_DATA_W'(tw));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur.timeout_us = 16'(to);
    cur.min_distance = 16'(mn);
    cur.max_distance = 16'(mx);
    cur.gap_ticks = 20'(gap);
    cur.samples_wanted = 4'(sw);
    cur.tries_allowed = 4'(ta);
    cur.trigger_width = 8'(tw);
    settings++;
  endtask

  task automatic rand_cfg();
    int unsigned to, mn, mx, gap, sw, ta, tw;
    to  = ($urandom_range(9, 0) == 0) ? 65535 : $urandom_range(12, 0);
    mn  = $urandom_range(20, 0);
    mx  = ($urandom_range(9, 0) == 0) ? 65535 : $urandom_range(52, 0);
    gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(5, 0);
    sw  = ($urandom_range(7, 0) == 0) ? $urandom_range(15, 8) : $urandom_range(5, 0);
    ta  = ($urandom_range(7, 0) == 0) ? 15 : $urandom_range(6, 0);
    tw  = $urandom_range(4, 0);
    if ($urandom_range(19, 0) == 0) begin
      tw = 255;
      ta = $urandom_range(2, 0);
    end
    set_cfg(to, mn, mx, gap, sw, ta, tw);
  endtask

  // one try: trigger, echo low for r ticks, then high for h ticks, lined up with the block
  task automatic one_try(input bit first, input int unsigned r, input int unsigned h);
    int unsigned tw;
    tw = (cur.trigger_width == 0) ? 1 : cur.trigger_width;
    send_beat(first ? 1'b1 : stray_cmd(), rand_bit());
    repeat (1 + tw) send_beat(stray_cmd(), rand_bit());
    if (r > cur.timeout_us) begin
      repeat (cur.timeout_us + 1) send_beat(stray_cmd(), 1'b0);
      return;
    end
    repeat (r) send_beat(stray_cmd(), 1'b0);
    if (h - 1 > cur.timeout_us) begin
      repeat (cur.timeout_us + 2) send_beat(stray_cmd(), 1'b1);
      return;
    end
    repeat (h) send_beat(stray_cmd(), 1'b1);
    send_beat(stray_cmd(), 1'b0);
  endtask

  task automatic measure(input int unsigned rmax, input int unsigned hmax);
    int unsigned want, good, t, r, h, d;
    want = (cur.samples_wanted > 8) ? 8 : cur.samples_wanted;
    good = 0;
    t = 0;
    if (want == 0 || cur.tries_allowed == 0) begin
      send_beat(1'b1, rand_bit());
      return;
    end
    while (good < want && t < cur.tries_allowed) begin
      r = $urandom_range(rmax, 0);
      h = $urandom_range(hmax, 1);
      one_try(t == 0, r, h);
      d = (h * DIST_SCALE) >> DIST_SHIFT;
      if (r <= cur.timeout_us && h - 1 <= cur.timeout_us &&
          d >= cur.min_distance && d <= cur.max_distance) good++;
      t++;
      noise_ticks(cur.gap_ticks);
    end
    send_beat(stray_cmd(), rand_bit());
  endtask

  initial begin
    int unsigned phase_no, target, pick, rmax;
    bit          held_once;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_TIMEOUT;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    cmd_i = 1'b0;
    echo_i = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    hold_reqs = 0;
    beats = 0;
    settings = 0;
    held_once = 1'b0;
    cur.timeout_us = TIMEOUT_RST;
    cur.min_distance = MIN_DIST_RST;
    cur.max_distance = MAX_DIST_RST;
    cur.gap_ticks = GAP_RST;
    cur.samples_wanted = SAMPLES_RST;
    cur.tries_allowed = TRIES_RST;
    cur.trigger_width = TRIG_W_RST;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // plain ticks under the reset settings
    send_beat(1'b0, 1'b0);
    send_beat(1'b0, 1'b1);
    // no samples wanted, then no tries allowed: done on the start tick
    set_cfg(3, 0, 65535, 0, 0, 5, 1);
    send_beat(1'b1, 1'b0);
    send_beat(1'b0, 1'b1);
    set_cfg(3, 0, 65535, 0, 5, 0, 1);
    send_beat(1'b1, 1'b1);
    // zero timeout, zero trigger width, sample count above the store size, all tries
    set_cfg(0, 0, 65535, 1, 15, 15, 0);
    measure(1, 2);
    // full store with an even count of eight, then an odd count of seven
    set_cfg(20, 0, 65535, 0, 8, 15, 2);
    measure(3, 21);
    set_cfg(20, 0, 65535, 0, 7, 15, 2);
    measure(3, 21);
    // empty accept window: nothing is found
    set_cfg(5, 65535, 0, 2, 3, 3, 1);
    measure(4, 10);
    // widest timeout and widest trigger
    set_cfg(65535, 0, 65535, 0, 1, 1, 255);
    one_try(1'b1, 0, 5);
    send_beat(1'b0, 1'b0);
    // widest gap, cut short by a write while the measurement is running
    set_cfg(5, 0, 65535, 1048575, 1, 1, 1);
    one_try(1'b1, 2, 4);
    noise_ticks(40);
    set_cfg(5, 0, 65535, 0, 1, 1, 1);
    send_beat(1'b0, 1'b1);

    for (phase_no = 0; phase_no < 4; phase_no++) begin
      case (phase_no)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 81;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 81;
        end
        default: begin
          idle_pct = 25;
          stall_pct = 25;
        end
      endcase
      target = beats + RANDOM_BEATS / 4;
      rand_cfg();
      while (beats < target) begin
        pick = $urandom_range(99, 0);
        rmax = (cur.timeout_us < 13) ? cur.timeout_us + 2 : 12;
        if (pick < 20) begin
          rand_cfg();
        end else if (pick < 32) begin
          repeat ($urandom_range(20, 1)) send_beat(rand_bit(), rand_bit());
        end else begin
          measure(rmax, 30);
        end
        if (phase_no == 0 && !held_once && beats + 200 > target) begin
          hold_reqs++;
          held_once = 1'b1;
        end
      end
    end

    drain();
    repeat (5) @(negedge clk_i);
    $display("%0d input beats under %0d register settings, all four stall patterns",
             beats, settings);
    $display("%0d measurements finished, %0d of them with a reading", done_cnt, found_cnt);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
